### rtl/core/fractional_order_state_space_step_macros.svh
// assertion macros used by the checker
`ifndef FRACTIONAL_ORDER_STATE_SPACE_STEP_MACROS_SVH
`define FRACTIONAL_ORDER_STATE_SPACE_STEP_MACROS_SVH

// plain clocked property with reset disable
`define FOSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled word keeps valid and data
`define FOSS_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, dat, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        vld && !rdy |=> vld && $stable(dat)) else $error(msg);

`endif

### rtl/core/foss_pkg.sv
package foss_pkg;

    localparam int FOSS_HIST = 64;
    localparam int DW        = 16;
    localparam int WW        = 32;
    localparam int ACCW      = 64;
    localparam int CFG_IW    = 3;

    localparam logic signed [WW-1:0] W_ONE = 32'sd16777216;

    localparam logic [CFG_IW-1:0] REG_A_MATRIX      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_B_MATRIX      = 3'd1;
    localparam logic [CFG_IW-1:0] REG_C_MATRIX      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_ORDER_FIRST   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ORDER_SECOND  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_INITIAL_STATE = 3'd5;

    typedef struct packed {
        logic valid;
        logic neg;
        logic shl;
    } mac_ctl_t;

    // round to nearest, ties away from zero, then saturate to 16 bits
    function automatic logic signed [DW-1:0] round_sat(input logic signed [ACCW-1:0] v,
                                                      input int unsigned sh);
        logic [ACCW-1:0] mag;
        logic [ACCW-1:0] half;
        logic signed [ACCW-1:0] r;
        half = 64'd1 << (sh - 1);
        if (!v[ACCW-1]) begin
            mag = v;
            r = $signed((mag + half) >> sh);
        end else begin
            mag = -v;
            r = -$signed((mag + half) >> sh);
        end
        if (r > 64'sd32767) begin
            round_sat = 16'sh7fff;
        end else if (r < -64'sd32768) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = r[DW-1:0];
        end
    endfunction

endpackage

### rtl/core/foss_mac.sv
module foss_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  foss_pkg::mac_ctl_t           ctl,
    input  logic signed [31:0]           op_a,
    input  logic signed [15:0]           op_b,
    output logic signed [63:0]           acc
);
    import foss_pkg::*;

    mac_ctl_t                 ctl_reg;
    logic signed [47:0]       prod_reg;
    logic signed [47:0]       prod_next;
    logic signed [ACCW-1:0]   acc_reg;
    logic signed [ACCW-1:0]   ext;
    logic signed [ACCW-1:0]   term;

    assign prod_next = op_a * op_b;
    assign ext  = {{(ACCW-48){prod_reg[47]}}, prod_reg};
    assign term = ctl_reg.shl ? (ext <<< 12) : ext;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            ctl_reg <= '0;
            acc_reg <= '0;
        end else begin
            ctl_reg <= ctl;
            if (clear) begin
                acc_reg <= '0;
            end else if (ctl_reg.valid) begin
                acc_reg <= ctl_reg.neg ? (acc_reg - term) : (acc_reg + term);
            end
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/core/foss_hist.sv
module foss_hist #(
    parameter int HIST = foss_pkg::FOSS_HIST
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [$clog2(HIST)-1:0]     rd_addr,
    output logic [31:0]                 rd_data,
    input  logic                        step_we,
    input  logic [31:0]                 step_data,
    input  logic                        init_we,
    input  logic [31:0]                 init_data,
    output logic [$clog2(HIST)-1:0]     newest
);
    import foss_pkg::*;

    localparam int SW = $clog2(HIST);
    localparam int FW = $clog2(HIST + 1);

    logic [31:0]   mem [0:HIST-1];
    logic [31:0]   q_reg;
    logic          qv_reg;
    logic [SW-1:0] ws_reg;
    logic [FW-1:0] fill_reg;
    logic          nv_reg;
    logic          rd_valid;

    assign newest   = (ws_reg == '0) ? SW'(HIST - 1) : ws_reg - 1'b1;
    // an entry never written reads as zero
    assign rd_valid = (FW'(rd_addr) < fill_reg) || ((rd_addr == SW'(HIST - 1)) && nv_reg);

    always_ff @(posedge aclk) begin
        if (step_we) begin
            mem[ws_reg] <= step_data;
        end else if (init_we) begin
            mem[newest] <= init_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg   <= '0;
            fill_reg <= '0;
            nv_reg   <= 1'b0;
            qv_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                qv_reg <= rd_valid;
            end
            if (step_we) begin
                ws_reg <= (ws_reg == SW'(HIST - 1)) ? '0 : ws_reg + 1'b1;
                if (fill_reg != FW'(HIST)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end else if (init_we && (ws_reg == '0)) begin
                nv_reg <= 1'b1;
            end
        end
    end

    assign rd_data = qv_reg ? q_reg : '0;

endmodule

### rtl/core/foss_wgen.sv
module foss_wgen #(
    parameter int HIST = foss_pkg::FOSS_HIST
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [13:0]                 order_first,
    input  logic [13:0]                 order_second,
    input  logic                        rd_en,
    input  logic                        rd_sel,
    input  logic [$clog2(HIST)-1:0]     rd_idx,
    output logic signed [31:0]          rd_w,
    output logic                        busy
);
    import foss_pkg::*;

    localparam int JW  = $clog2(HIST);
    localparam int AW  = $clog2(2 * HIST);
    localparam int DFW = JW + 14;
    localparam int PW  = WW + DFW;
    localparam int DVW = PW - 12;
    localparam int CW  = $clog2(DVW + 1);

    typedef enum logic [2:0] {W_IDLE, W_MUL, W_PREP, W_DIV, W_WR} wstate_t;

    logic signed [WW-1:0] wmem [0:2*HIST-1];
    logic signed [WW-1:0] rd_w_reg;

    wstate_t              st_reg;
    logic                 sel_reg;
    logic [JW-1:0]        j_reg;
    logic signed [WW-1:0] w_reg;
    logic signed [PW-1:0] prod_reg;
    logic [DVW-1:0]       num_reg;
    logic [JW:0]          rem_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;

    logic [13:0]          ord;
    logic [JW-1:0]        jm1;
    logic signed [DFW-1:0] diff;
    logic [PW-1:0]        mag;
    logic [JW:0]          remsh;
    logic signed [WW-1:0] wnew;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;

    assign ord   = sel_reg ? order_second : order_first;
    assign jm1   = j_reg - 1'b1;
    assign diff  = $signed(DFW'(ord)) - $signed(DFW'(jm1) << 12);
    assign mag   = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign remsh = {rem_reg[JW-1:0], num_reg[DVW-1]};
    assign wnew  = neg_reg ? -$signed(WW'(num_reg)) : $signed(WW'(num_reg));
    assign waddr = sel_reg ? AW'(HIST) + AW'(j_reg) : AW'(j_reg);
    assign raddr = rd_sel ? AW'(HIST) + AW'(rd_idx) : AW'(rd_idx);

    always_ff @(posedge aclk) begin
        if (st_reg == W_WR) begin
            wmem[waddr] <= wnew;
        end
        if (rd_en) begin
            rd_w_reg <= wmem[raddr];
        end
    end

    // w_j = trunc(trunc(w_{j-1} * diff / 4096) / j), one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= W_IDLE;
            sel_reg <= 1'b0;
            j_reg   <= '0;
            w_reg   <= W_ONE;
            cnt_reg <= '0;
        end else begin
            case (st_reg)
                W_IDLE: begin
                    if (start) begin
                        sel_reg <= 1'b0;
                        j_reg   <= JW'(1);
                        w_reg   <= W_ONE;
                        st_reg  <= W_MUL;
                    end
                end
                W_MUL: begin
                    prod_reg <= w_reg * diff;
                    st_reg   <= W_PREP;
                end
                W_PREP: begin
                    num_reg <= mag[PW-1:12];
                    neg_reg <= prod_reg[PW-1];
                    rem_reg <= '0;
                    cnt_reg <= CW'(DVW);
                    st_reg  <= W_DIV;
                end
                W_DIV: begin
                    if (remsh >= {1'b0, j_reg}) begin
                        rem_reg <= remsh - {1'b0, j_reg};
                        num_reg <= {num_reg[DVW-2:0], 1'b1};
                    end else begin
                        rem_reg <= remsh;
                        num_reg <= {num_reg[DVW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        st_reg <= W_WR;
                    end
                end
                W_WR: begin
                    w_reg <= wnew;
                    if (j_reg == JW'(HIST - 1)) begin
                        if (sel_reg) begin
                            st_reg <= W_IDLE;
                        end else begin
                            sel_reg <= 1'b1;
                            j_reg   <= JW'(1);
                            w_reg   <= W_ONE;
                            st_reg  <= W_MUL;
                        end
                    end else begin
                        j_reg  <= j_reg + 1'b1;
                        st_reg <= W_MUL;
                    end
                end
                default: begin
                    st_reg <= W_IDLE;
                end
            endcase
        end
    end

    assign rd_w = rd_w_reg;
    assign busy = (st_reg != W_IDLE);

endmodule

### rtl/core/fractional_order_state_space_step.sv
// one multiply-accumulate computes each result, walking HIST-1 history slots per state plus
// matrix terms; words are taken one at a time, and the next word is taken while a result waits on m_
// reset (and every order write) rebuilds the weight table, s_tready low meanwhile
// history reads zero until written; write slot and fill count clear on reset
module fractional_order_state_space_step #(
    parameter int HIST = foss_pkg::FOSS_HIST
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // drive_first, drive_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_first, out_second
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import foss_pkg::*;

    localparam int IW = $clog2(HIST);

    typedef enum logic [3:0] {
        S_WSTART, S_WWAIT, S_IDLE, S_PREV, S_MAT, S_MEM, S_DRAIN,
        S_RND, S_CMAT, S_CDRAIN, S_CRND, S_OUT
    } state_t;

    state_t               state_reg;
    logic                 recalc_reg;
    logic [63:0]          a_reg;
    logic [63:0]          b_reg;
    logic [63:0]          c_reg;
    logic [13:0]          ord0_reg;
    logic [13:0]          ord1_reg;
    logic signed [DW-1:0] u0_reg;
    logic signed [DW-1:0] u1_reg;
    logic signed [DW-1:0] xp0_reg;
    logic signed [DW-1:0] xp1_reg;
    logic signed [DW-1:0] xn0_reg;
    logic signed [DW-1:0] xn1_reg;
    logic signed [DW-1:0] y0_reg;
    logic signed [DW-1:0] y1_reg;
    logic                 i_reg;
    logic [1:0]           k_reg;
    logic [IW-1:0]        j_reg;
    logic [IW-1:0]        ptr_reg;
    logic                 dcnt_reg;
    mac_ctl_t             tag_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;

    logic                 cfg_we;
    logic                 hist_rd_en;
    logic [IW-1:0]        hist_rd_addr;
    logic [31:0]          hist_q;
    logic                 step_we;
    logic                 init_we;
    logic [IW-1:0]        newest;
    logic signed [WW-1:0] w_q;
    logic                 wg_busy;
    logic                 mac_clear;
    mac_ctl_t             mac_ctl;
    logic signed [31:0]   mac_a;
    logic signed [15:0]   mac_b;
    logic signed [63:0]   acc;
    logic [1:0]           eidx;
    logic signed [DW-1:0] coef;

    function automatic logic signed [DW-1:0] entry(input logic [63:0] m, input logic [1:0] idx);
        entry = m[idx*16 +: 16];
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign init_we   = cfg_we && (cfg_index == REG_INITIAL_STATE);
    assign s_tready  = (state_reg == S_IDLE) && !recalc_reg;

    assign hist_rd_en   = (state_reg == S_IDLE) || (state_reg == S_MEM);
    assign hist_rd_addr = (state_reg == S_MEM) ? ptr_reg : newest;
    assign step_we      = (state_reg == S_CMAT) && !i_reg && !k_reg[0];
    assign mac_clear    = (state_reg == S_PREV) || (state_reg == S_RND) || (state_reg == S_CRND);

    always_comb begin
        eidx  = {i_reg, k_reg[0]};
        coef  = '0;
        mac_a = w_q;
        mac_b = i_reg ? $signed(hist_q[31:16]) : $signed(hist_q[15:0]);
        mac_ctl = tag_reg;
        case (state_reg)
            S_MAT: begin
                coef = k_reg[1] ? entry(b_reg, eidx) : entry(a_reg, eidx);
                mac_a = WW'(coef);
                case (k_reg)
                    2'd0:    mac_b = xp0_reg;
                    2'd1:    mac_b = xp1_reg;
                    2'd2:    mac_b = u0_reg;
                    default: mac_b = u1_reg;
                endcase
                mac_ctl = '{valid: 1'b1, neg: 1'b0, shl: 1'b1};
            end
            S_CMAT: begin
                coef = entry(c_reg, eidx);
                mac_a = WW'(coef);
                mac_b = k_reg[0] ? xn1_reg : xn0_reg;
                mac_ctl = '{valid: 1'b1, neg: 1'b0, shl: 1'b0};
            end
            default: begin
                coef = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg    <= '0;
            b_reg    <= '0;
            c_reg    <= '0;
            ord0_reg <= 14'd4096;
            ord1_reg <= 14'd4096;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_A_MATRIX:     a_reg    <= cfg_data;
                REG_B_MATRIX:     b_reg    <= cfg_data;
                REG_C_MATRIX:     c_reg    <= cfg_data;
                REG_ORDER_FIRST:  ord0_reg <= cfg_data[13:0];
                REG_ORDER_SECOND: ord1_reg <= cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_WSTART;
            recalc_reg   <= 1'b0;
            i_reg        <= 1'b0;
            k_reg        <= '0;
            j_reg        <= '0;
            ptr_reg      <= '0;
            dcnt_reg     <= 1'b0;
            tag_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // odd lags add, even lags subtract
            if (state_reg == S_MEM) begin
                tag_reg <= '{valid: 1'b1, neg: !j_reg[0], shl: 1'b0};
            end else begin
                tag_reg <= '0;
            end
            if ((state_reg == S_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_WSTART: begin
                    state_reg <= S_WWAIT;
                end
                S_WWAIT: begin
                    if (!wg_busy) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (recalc_reg) begin
                        state_reg  <= S_WSTART;
                    end else if (s_tvalid) begin
                        u0_reg    <= s_tdata[15:0];
                        u1_reg    <= s_tdata[31:16];
                        state_reg <= S_PREV;
                    end
                end
                S_PREV: begin
                    xp0_reg   <= hist_q[15:0];
                    xp1_reg   <= hist_q[31:16];
                    i_reg     <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= S_MAT;
                end
                S_MAT: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3) begin
                        j_reg     <= IW'(1);
                        ptr_reg   <= newest;
                        state_reg <= S_MEM;
                    end
                end
                S_MEM: begin
                    ptr_reg <= (ptr_reg == '0) ? IW'(HIST - 1) : ptr_reg - 1'b1;
                    j_reg   <= j_reg + 1'b1;
                    if (j_reg == IW'(HIST - 1)) begin
                        dcnt_reg  <= 1'b1;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    dcnt_reg <= 1'b0;
                    if (!dcnt_reg) begin
                        state_reg <= S_RND;
                    end
                end
                S_RND: begin
                    k_reg <= '0;
                    if (!i_reg) begin
                        xn0_reg   <= round_sat(acc, 24);
                        i_reg     <= 1'b1;
                        state_reg <= S_MAT;
                    end else begin
                        xn1_reg   <= round_sat(acc, 24);
                        i_reg     <= 1'b0;
                        state_reg <= S_CMAT;
                    end
                end
                S_CMAT: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg[0]) begin
                        state_reg <= S_CDRAIN;
                    end
                end
                S_CDRAIN: begin
                    state_reg <= S_CRND;
                end
                S_CRND: begin
                    k_reg <= '0;
                    if (!i_reg) begin
                        y0_reg    <= round_sat(acc, 12);
                        i_reg     <= 1'b1;
                        state_reg <= S_CMAT;
                    end else begin
                        y1_reg    <= round_sat(acc, 12);
                        i_reg     <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= {y1_reg, y0_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_we && ((cfg_index == REG_ORDER_FIRST) || (cfg_index == REG_ORDER_SECOND))) begin
                recalc_reg <= 1'b1;
            end else if (state_reg == S_IDLE) begin
                recalc_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    foss_hist #(.HIST(HIST)) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (hist_rd_en),
        .rd_addr   (hist_rd_addr),
        .rd_data   (hist_q),
        .step_we   (step_we),
        .step_data ({xn1_reg, xn0_reg}),
        .init_we   (init_we),
        .init_data (cfg_data[31:0]),
        .newest    (newest)
    );

    foss_wgen #(.HIST(HIST)) u_wgen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (state_reg == S_WSTART),
        .order_first  (ord0_reg),
        .order_second (ord1_reg),
        .rd_en        (state_reg == S_MEM),
        .rd_sel       (i_reg),
        .rd_idx       (j_reg),
        .rd_w         (w_q),
        .busy         (wg_busy)
    );

    foss_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (mac_clear),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (acc)
    );

endmodule

### rtl/core/foss_chk.sv
`include "fractional_order_state_space_step_macros.svh"

module foss_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `FOSS_ASSERT_HOLD(a_out_hold, aclk, aresetn, m_tvalid, m_tready, m_tdata, "result word dropped")
    `FOSS_ASSERT(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second word taken")
    `FOSS_ASSERT(a_no_early, aclk, aresetn, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "early result")

endmodule

bind fractional_order_state_space_step foss_chk u_foss_chk (.*);

### bench/tb_fractional_order_state_space_step.sv
module tb_fractional_order_state_space_step;
    import foss_pkg::*;

    localparam int NSLOT     = FOSS_HIST;
    localparam int LIMIT     = 2000000;
    localparam int HOLD_LEN  = 800;
    localparam int TAIL_WAIT = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // drive_first, drive_second
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // out_first, out_second
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    fractional_order_state_space_step i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor copy of the block
    logic [63:0]        mat_a = '0, mat_b = '0, mat_c = '0;
    logic [13:0]        ord0 = 14'd4096, ord1 = 14'd4096;
    logic signed [15:0] hist0 [NSLOT];
    logic signed [15:0] hist1 [NSLOT];
    int                 wslot = 0;

    logic [31:0] drive_q [$];
    logic [31:0] expected_out_q [$];
    int          offered = 0;
    int          acc_cnt = 0;
    int          out_cnt = 0;
    int          errors = 0;
    int          cyc = 0;
    int          cfg_writes = 0;
    bit          idle_on = 1'b1;
    bit          hold_kick = 1'b0;

    initial begin
        for (int k = 0; k < NSLOT; k++) begin
            hist0[k] = '0;
            hist1[k] = '0;
        end
    end

    function automatic logic signed [15:0] round_to_q12(longint v, int sh);
        longint half, r;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0) r = (v + half) >>> sh;
        else        r = -((-v + half) >>> sh);
        if (r > 32767)  r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint mat_el(logic [63:0] m, int r, int c);
        logic signed [15:0] e;
        e = m[(r*2+c)*16 +: 16];
        return longint'(e);
    endfunction

    function automatic logic signed [15:0] hist_at(int i, int slot);
        return (i == 0) ? hist0[slot] : hist1[slot];
    endfunction

    function automatic logic [31:0] advance_state(logic [31:0] drive);
        longint u [2];
        longint acc, w, ordv, diff;
        logic signed [15:0] xn [2];
        logic signed [15:0] y [2];
        int prev;
        u[0] = longint'($signed(drive[15:0]));
        u[1] = longint'($signed(drive[31:16]));
        prev = (wslot + NSLOT - 1) % NSLOT;
        for (int i = 0; i < 2; i++) begin
            acc = 0;
            w = longint'(1) <<< 24;
            ordv = (i == 0) ? longint'(ord0) : longint'(ord1);
            for (int c = 0; c < 2; c++) begin
                acc += mat_el(mat_a, i, c) * longint'(hist_at(c, prev)) * 4096;
                acc += mat_el(mat_b, i, c) * u[c] * 4096;
            end
            for (int j = 1; j < NSLOT; j++) begin
                diff = ordv - longint'(j - 1) * 4096;
                w = (w * diff) / (longint'(j) * 4096);
                if (j % 2 == 1) acc += w * longint'(hist_at(i, (wslot + NSLOT - j) % NSLOT));
                else            acc -= w * longint'(hist_at(i, (wslot + NSLOT - j) % NSLOT));
            end
            xn[i] = round_to_q12(acc, 24);
        end
        hist0[wslot] = xn[0];
        hist1[wslot] = xn[1];
        for (int i = 0; i < 2; i++) begin
            acc = 0;
            for (int c = 0; c < 2; c++) acc += mat_el(mat_c, i, c) * longint'(xn[c]);
            y[i] = round_to_q12(acc, 12);
        end
        wslot = (wslot + 1) % NSLOT;
        return {y[1], y[0]};
    endfunction

    // input acceptance and prediction
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_out_q.push_back(advance_state(s_tdata));
            acc_cnt++;
        end
    end

    // sender
    int s_gap = 0;
    always @(negedge aclk) begin
        if (!(s_tvalid && acc_cnt < offered)) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap--;
            end else if (aresetn && offered < drive_q.size()) begin
                s_tdata <= drive_q[offered];
                s_tvalid <= 1'b1;
                offered++;
                if (idle_on && $urandom_range(0, 3) == 0) s_gap = $urandom_range(1, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    int  r_stall = 0;
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(negedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (r_stall > 0) begin
            m_tready <= 1'b0;
            r_stall--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            r_stall = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checking
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            out_cnt++;
            if (expected_out_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_out_q.pop_front();
                if (want[15:0] != m_tdata[15:0]) begin
                    $display("%0t: out_first expected %0d actual %0d", $time,
                             $signed(want[15:0]), $signed(m_tdata[15:0]));
                    errors++;
                end
                if (want[31:16] != m_tdata[31:16]) begin
                    $display("%0t: out_second expected %0d actual %0d", $time,
                             $signed(want[31:16]), $signed(m_tdata[31:16]));
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_register(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_A_MATRIX:      mat_a = val;
            REG_B_MATRIX:      mat_b = val;
            REG_C_MATRIX:      mat_c = val;
            REG_ORDER_FIRST:   ord0 = val[13:0];
            REG_ORDER_SECOND:  ord1 = val[13:0];
            REG_INITIAL_STATE: begin
                hist0[(wslot + NSLOT - 1) % NSLOT] = val[15:0];
                hist1[(wslot + NSLOT - 1) % NSLOT] = val[31:16];
            end
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (acc_cnt < drive_q.size() || expected_out_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_matrix();
        logic [63:0] m;
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        for (int k = 0; k < 4; k++) m[k*16 +: 16] = 16'($signed($urandom_range(0, 4096)) - 2048);
        return m;
    endfunction

    function automatic logic [63:0] pick_order();
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return 64'd8192;
            2: return 64'd16383;
            default: return 64'($urandom_range(0, 8192));
        endcase
    endfunction

    function automatic logic [31:0] pick_drive();
        logic [31:0] d;
        if ($urandom_range(0, 2) == 0) return $urandom;
        d[15:0]  = 16'($signed($urandom_range(0, 8192)) - 4096);
        d[31:16] = 16'($signed($urandom_range(0, 8192)) - 4096);
        return d;
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values
        for (int k = 0; k < 3; k++) drive_q.push_back(pick_drive());
        wait_drained();

        // directed extremes
        write_register(REG_A_MATRIX, 64'h0800_0000_0000_0800);
        write_register(REG_B_MATRIX, 64'h1000_0000_0000_1000);
        write_register(REG_C_MATRIX, 64'h1000_0000_0000_1000);
        write_register(REG_ORDER_FIRST, 64'd2048);
        write_register(REG_ORDER_SECOND, 64'd8192);
        write_register(REG_INITIAL_STATE, 64'h8000_7fff);
        write_register(3'd6, {$urandom, $urandom});
        write_register(3'd7, {$urandom, $urandom});
        drive_q.push_back(32'h7fff_7fff);
        drive_q.push_back(32'h8000_8000);
        drive_q.push_back(32'h0000_0000);
        drive_q.push_back(32'h0001_ffff);
        drive_q.push_back(32'h8000_7fff);
        drive_q.push_back(32'h5555_aaaa);
        drive_q.push_back(32'haaaa_5555);
        wait_drained();

        // order zero and order just under four, saturating matrices
        write_register(REG_ORDER_FIRST, 64'd0);
        write_register(REG_ORDER_SECOND, 64'd16383);
        write_register(REG_A_MATRIX, 64'h7fff_8000_8000_7fff);
        write_register(REG_C_MATRIX, 64'h7fff_7fff_8000_8000);
        for (int k = 0; k < 4; k++) drive_q.push_back(k[0] ? 32'h7fff_8000 : 32'h8000_7fff);
        wait_drained();
        // initial state load between words
        write_register(REG_INITIAL_STATE, 64'h1234_edcb);
        for (int k = 0; k < 4; k++) drive_q.push_back(pick_drive());
        wait_drained();

        // random phases, one with a long receiver hold
        for (int ph = 0; ph < 10; ph++) begin
            write_register(REG_A_MATRIX, pick_matrix());
            write_register(REG_B_MATRIX, pick_matrix());
            write_register(REG_C_MATRIX, pick_matrix());
            write_register(REG_ORDER_FIRST, pick_order());
            write_register(REG_ORDER_SECOND, pick_order());
            if ($urandom_range(0, 1)) write_register(REG_INITIAL_STATE, {32'h0, $urandom});
            if (ph == 9) idle_on = 1'b0;
            for (int k = 0; k < 153; k++) drive_q.push_back(pick_drive());
            if (ph == 2) hold_kick = ~hold_kick;
            wait_drained();
        end

        $display("%0d words sent, %0d results checked, %0d register writes", acc_cnt,
                 out_cnt, cfg_writes);
        $display("covered reset values, field extremes, orders zero to near four, saturation");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
